// File: rtl/deq_pkg.sv
// Shared types, constants and index helpers for the double-ended queue.
// Used by the controller, the datapath and the top level; depends on nothing.
package deq_pkg;

  // Ring size and the widths that follow from it.
  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Fixed field widths of the request and result.
  localparam int VALUE_W  = 32;
  localparam int ICOUNT_W = 5;

  // Request commands.
  typedef enum logic [1:0] {
    CMD_INS_FRONT = 2'd0,
    CMD_INS_REAR  = 2'd1,
    CMD_DEL_FRONT = 2'd2,
    CMD_DEL_REAR  = 2'd3
  } cmd_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // a request is taken this cycle
    logic read_en;  // read the front and rear slots
    logic load;     // load the result registers
  } ctrl_t;

  // Advance a ring index by one slot, wrapping at the end.
  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
    logic [IDX_W:0] sum;
    sum = {1'b0, i} + (IDX_W + 1)'(1);
    return (sum >= (IDX_W + 1)'(DEPTH)) ? '0 : sum[IDX_W-1:0];
  endfunction

  // Step a ring index back by one slot, wrapping at the start.
  function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
  endfunction

endpackage

// File: rtl/double_ended_queue_core.sv
// Double-ended queue core on a ring of DEPTH slots with head and tail pointers.
// An accepted request is taken, its front and rear slots get a registered read, and
// the result is loaded once the output register is free. A new request is taken
// only after the result of the last one has been loaded.
// Reset (rst, synchronous) empties the queue; slot contents are not cleared.
module double_ended_queue_core
  import deq_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                cmd,
  input  logic signed [VALUE_W-1:0] item_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                status,
  output logic signed [VALUE_W-1:0] front_item,
  output logic signed [VALUE_W-1:0] rear_item,
  output logic [ICOUNT_W-1:0]       item_count,
  output logic                      is_empty
);

  ctrl_t ctrl;

  // Controller: request handshake and sequencing.
  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .ctrl      (ctrl)
  );

  // Datapath: ring pointers, slot store and result registers.
  deq_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .cmd        (cmd),
    .item_value (item_value),
    .status     (status),
    .front_item (front_item),
    .rear_item  (rear_item),
    .item_count (item_count),
    .is_empty   (is_empty)
  );

`ifndef SYNTHESIS
  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.load |-> (!out_valid || out_ready))
    else $error("result loaded over a pending result");

  // One request at a time: the input closes right after a request is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in flight");

  // An empty queue reports zero front and rear items.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_empty) |-> (front_item == '0 && rear_item == '0))
    else $error("empty queue reports nonzero items");

  // A rejected insert only happens on a full ring.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (item_count == ICOUNT_W'(DEPTH)))
    else $error("full status with a ring that is not full");
`endif

endmodule

// File: rtl/deq_ram.sv
// Generic RAM with one write port and two registered read ports.
// Stands alone; holds the slots of the ring.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                           rdata_a,
  output logic [WIDTH-1:0]                           rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read ports; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: rtl/deq_ctrl.sv
// Controller state machine of the double-ended queue.
// Depends on deq_pkg for the command struct.
module deq_ctrl
  import deq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  out_ready,
  output logic  out_valid,
  output ctrl_t ctrl
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_LOAD = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Sequence: take the request, read the slots, then load the result
  // once the output register is free.
  always_comb begin
    state_next   = state;
    ctrl.accept  = 1'b0;
    ctrl.read_en = 1'b0;
    ctrl.load    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.accept = 1'b1;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        ctrl.read_en = 1'b1;
        state_next   = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          ctrl.load  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // The result stays valid until it is taken.
  always_comb begin
    if (ctrl.load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: rtl/deq_datapath.sv
// Datapath of the double-ended queue: pointers, count, slot RAM, result registers.
// Depends on deq_pkg and deq_ram.
module deq_datapath
  import deq_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  ctrl_t                      ctrl,
  input  logic [1:0]                 cmd,
  input  logic signed [VALUE_W-1:0]  item_value,
  output logic [1:0]                 status,
  output logic signed [VALUE_W-1:0]  front_item,
  output logic signed [VALUE_W-1:0]  rear_item,
  output logic [ICOUNT_W-1:0]        item_count,
  output logic                       is_empty
);

  logic [IDX_W-1:0]   head, head_next;
  logic [IDX_W-1:0]   tail, tail_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  status_t            st_q, st_next;
  logic               ins_ok;
  logic [IDX_W-1:0]   waddr;
  logic               full, empty;
  logic [VALUE_W-1:0] rdata_a, rdata_b;
  logic [CNT_W+ICOUNT_W-1:0] cnt_wide;

  assign full  = (cnt == CNT_W'(DEPTH));
  assign empty = (cnt == '0);

  // Work out the new pointers, count and status of the incoming request.
  always_comb begin
    head_next = head;
    tail_next = tail;
    cnt_next  = cnt;
    st_next   = ST_OK;
    ins_ok    = 1'b0;
    waddr     = tail;
    unique case (cmd_t'(cmd))
      CMD_INS_FRONT: begin
        if (full) begin
          st_next = ST_FULL;
        end else begin
          head_next = idx_prev(head);
          waddr     = idx_prev(head);
          ins_ok    = 1'b1;
          cnt_next  = cnt + CNT_W'(1);
        end
      end
      CMD_INS_REAR: begin
        if (full) begin
          st_next = ST_FULL;
        end else begin
          tail_next = idx_next(tail);
          waddr     = tail;
          ins_ok    = 1'b1;
          cnt_next  = cnt + CNT_W'(1);
        end
      end
      CMD_DEL_FRONT: begin
        if (empty) begin
          st_next = ST_EMPTY;
        end else begin
          head_next = idx_next(head);
          cnt_next  = cnt - CNT_W'(1);
        end
      end
      CMD_DEL_REAR: begin
        if (empty) begin
          st_next = ST_EMPTY;
        end else begin
          tail_next = idx_prev(tail);
          cnt_next  = cnt - CNT_W'(1);
        end
      end
      default: st_next = ST_OK;
    endcase
  end

  // Ring state, updated when a request is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      cnt  <= '0;
    end else if (ctrl.accept) begin
      head <= head_next;
      tail <= tail_next;
      cnt  <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      st_q <= st_next;
    end
  end

  // Slot store; the front and rear slots are read after the pointers move.
  deq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ctrl.accept && ins_ok),
    .waddr   (waddr),
    .wdata   ($unsigned(item_value)),
    .re      (ctrl.read_en),
    .raddr_a (head),
    .raddr_b (idx_prev(tail)),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign cnt_wide = {{ICOUNT_W{1'b0}}, cnt};

  // Result registers; an empty queue reports zero items.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      status     <= st_q;
      front_item <= empty ? '0 : $signed(rdata_a);
      rear_item  <= empty ? '0 : $signed(rdata_b);
      item_count <= cnt_wide[ICOUNT_W-1:0];
      is_empty   <= empty;
    end
  end

endmodule

// File: test/double_ended_queue_core_tb.sv
// Self-checking testbench for double_ended_queue_core: directed corner requests,
// then biased random traffic with random stalls on both handshakes.
// Depends on deq_pkg and the core RTL only.
`timescale 1ns / 100ps

// Shadow copy of the ring that predicts the result of every accepted request
// and checks each returned result against the oldest prediction.
class deq_shadow;
  typedef struct {
    deq_pkg::status_t               status;
    logic signed [deq_pkg::VALUE_W-1:0] front;
    logic signed [deq_pkg::VALUE_W-1:0] rear;
    logic [deq_pkg::ICOUNT_W-1:0]   count;
    logic                           empty;
  } deq_view_t;

  logic signed [deq_pkg::VALUE_W-1:0] ring[deq_pkg::DEPTH];
  int        head_slot;
  int        tail_slot;
  int        held;
  deq_view_t expected_views[$];
  int        errors;

  function new();
    head_slot = 0;
    tail_slot = 0;
    held      = 0;
    errors    = 0;
  endfunction

  function int ring_after(int i);
    return (i + 1) % deq_pkg::DEPTH;
  endfunction

  function int ring_before(int i);
    return (i + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
  endfunction

  function int pending();
    return expected_views.size();
  endfunction

  // Apply one accepted request to the shadow ring and queue its result.
  function void note_request(deq_pkg::cmd_t op, logic signed [deq_pkg::VALUE_W-1:0] v);
    deq_view_t r;
    r.status = deq_pkg::ST_OK;
    if (op == deq_pkg::CMD_INS_FRONT || op == deq_pkg::CMD_INS_REAR) begin
      if (held >= deq_pkg::DEPTH) begin
        r.status = deq_pkg::ST_FULL;
      end else if (op == deq_pkg::CMD_INS_FRONT) begin
        head_slot = ring_before(head_slot);
        ring[head_slot] = v;
        held++;
      end else begin
        ring[tail_slot] = v;
        tail_slot = ring_after(tail_slot);
        held++;
      end
    end else begin
      if (held == 0) begin
        r.status = deq_pkg::ST_EMPTY;
      end else if (op == deq_pkg::CMD_DEL_FRONT) begin
        head_slot = ring_after(head_slot);
        held--;
      end else begin
        tail_slot = ring_before(tail_slot);
        held--;
      end
    end
    // An empty queue reports zero at both ends.
    r.front = (held != 0) ? ring[head_slot] : '0;
    r.rear  = (held != 0) ? ring[ring_before(tail_slot)] : '0;
    r.count = held[deq_pkg::ICOUNT_W-1:0];
    r.empty = (held == 0);
    expected_views.push_back(r);
  endfunction

  function void compare_field(string name, logic signed [32:0] exp_v,
                              logic signed [32:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  // Check one returned result against the oldest prediction.
  function void check_result(logic [1:0] status, logic signed [deq_pkg::VALUE_W-1:0] front,
                             logic signed [deq_pkg::VALUE_W-1:0] rear,
                             logic [deq_pkg::ICOUNT_W-1:0] count, logic empty);
    deq_view_t e;
    if (expected_views.size() == 0) begin
      errors++;
      $display("%0t: result with no request waiting, expected none, actual status %0d",
               $time, status);
      return;
    end
    e = expected_views.pop_front();
    compare_field("status", e.status, status);
    compare_field("front_item", e.front, front);
    compare_field("rear_item", e.rear, rear);
    compare_field("item_count", e.count, count);
    compare_field("is_empty", e.empty, empty);
  endfunction
endclass

module double_ended_queue_core_tb;
  import deq_pkg::*;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic [1:0]                cmd;
  logic signed [VALUE_W-1:0] item_value;
  logic                      out_valid;
  logic                      out_ready;
  logic [1:0]                status;
  logic signed [VALUE_W-1:0] front_item;
  logic signed [VALUE_W-1:0] rear_item;
  logic [ICOUNT_W-1:0]       item_count;
  logic                      is_empty;

  // Stretches without idling on the request and result sides.
  bit tx_calm;
  bit rx_calm;

  deq_shadow shadow = new();

  double_ended_queue_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .item_value (item_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .front_item (front_item),
    .rear_item  (rear_item),
    .item_count (item_count),
    .is_empty   (is_empty)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("double_ended_queue_core test failed");
    $finish;
  end

  // Predict on every accepted request, check every accepted result.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) shadow.note_request(cmd_t'(cmd), item_value);
    if (!rst && out_valid && out_ready)
      shadow.check_result(status, front_item, rear_item, item_count, is_empty);
  end

  // Present one request after a random gap and hold it until accepted.
  task automatic send_request(cmd_t op, logic signed [VALUE_W-1:0] v);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= op;
    item_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (shadow.pending() != 0);
  endtask

  // Result side: random hold-off before each result, then ready until taken.
  task automatic take_results();
    int gap;
    forever begin
      gap = rx_calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7FFF_FFFF;
        2: return -32'sd1;
        default: return '0;
      endcase
    end
    return $urandom;
  endfunction

  initial begin
    int   seg_left;
    int   ins_pct;
    int   wait_cycles;
    cmd_t op;

    rst        <= 1'b1;
    in_valid   <= 1'b0;
    cmd        <= CMD_INS_FRONT;
    item_value <= '0;
    out_ready  <= 1'b0;
    tx_calm    = 1'b0;
    rx_calm    = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    fork
      take_results();
    join_none

    // Deletes on an empty queue, then extremes in and out.
    send_request(CMD_DEL_FRONT, 32'sd5);
    send_request(CMD_DEL_REAR, -32'sd5);
    send_request(CMD_INS_FRONT, 32'sh8000_0000);
    send_request(CMD_INS_REAR, 32'sh7FFF_FFFF);
    send_request(CMD_DEL_REAR, '0);
    send_request(CMD_DEL_FRONT, '0);

    // Fill the ring from both ends, wrapping the head below slot zero.
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 4)
        0: send_request(CMD_INS_FRONT, 32'sh8000_0000);
        1: send_request(CMD_INS_REAR, 32'sh7FFF_FFFF);
        2: send_request(CMD_INS_FRONT, -32'sd1);
        default: send_request(CMD_INS_REAR, $urandom);
      endcase
    end

    // Inserts into a full ring are rejected.
    send_request(CMD_INS_FRONT, 32'sd123);
    send_request(CMD_INS_REAR, -32'sd123);

    // Random traffic in segments that lean toward filling, draining or neither.
    seg_left = 0;
    ins_pct  = 50;
    for (int n = 0; n < 650; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0: ins_pct = 15;
          1: ins_pct = 50;
          default: ins_pct = 85;
        endcase
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
      end
      seg_left--;
      if (n == 325) drain_results();
      if ($urandom_range(0, 99) < ins_pct)
        op = $urandom_range(0, 1) ? CMD_INS_REAR : CMD_INS_FRONT;
      else
        op = $urandom_range(0, 1) ? CMD_DEL_REAR : CMD_DEL_FRONT;
      send_request(op, pick_value());
    end
    in_valid <= 1'b0;

    // Let the last results come back, then allow a few quiet cycles.
    wait_cycles = 0;
    while (shadow.pending() != 0 && wait_cycles < 2000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);
    if (shadow.pending() != 0) begin
      shadow.errors++;
      $display("%0t: results missing, expected %0d more, actual 0", $time, shadow.pending());
    end

    if (shadow.errors == 0) begin
      $display("double_ended_queue_core test passed");
    end else begin
      $display("double_ended_queue_core test failed");
    end
    $finish;
  end

endmodule
